// ===== hw/rtl/trd_pkg.sv =====
`default_nettype none
package trd_pkg;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int ONE_Q14 = 16384;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic [31:0]        fill_color;
        logic [15:0]        pixel_index;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        read_color;
        logic signed [15:0] read_depth;
        logic [16:0]        pixels_written;
        logic               degenerate;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic signed [47:0] num;
        logic signed [33:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [47:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== hw/rtl/trd_divider.sv =====
`default_nettype none
module trd_divider (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  trd_pkg::t_div_req   i_req,
    output trd_pkg::t_div_rsp   o_rsp
);

    logic [47:0] r_rem, n_rem;
    logic [47:0] r_quo, n_quo;
    logic [33:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [48:0] w_try;
    logic [47:0] w_shift;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_shift = {r_rem[46:0], r_quo[47]};
        w_try   = {1'b0, w_shift} - {15'd0, r_den};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.num[47] ? 48'(-i_req.num) : i_req.num;
            n_den  = i_req.den[33] ? 34'(-i_req.den) : i_req.den;
            n_neg  = i_req.num[47] ^ i_req.den[33];
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_try[48]) begin
                n_rem = w_try[47:0];
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[46:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? 48'(-r_quo) : r_quo;

endmodule
`default_nettype wire

// ===== hw/rtl/triangle_raster_depth_test.sv =====
// A clear writes every pixel of the screen, and a triangle is worked one pixel at a time
// over its clipped bounding box, row by row.
// One item is in work at a time; the 48-step serial divider, used twice per pixel,
// sets the per-pixel cost.
// Reset is synchronous and active low; it clears the control state and sets both
// screen registers to 256. The stores hold no defined value until a clear.
`default_nettype none
module triangle_raster_depth_test #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  trd_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output trd_pkg::t_out_item   o_out_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire                  i_cfg_index,
    input  wire [8:0]            i_cfg_data
);

    localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(SIZE);
    localparam int XW   = $clog2(MAX_WIDTH + 1);
    localparam int YW   = $clog2(MAX_HEIGHT + 1);
    localparam int SW   = 9;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_CLEAR = 13'b0000000000010,
        ST_READ  = 13'b0000000000100,
        ST_READ2 = 13'b0000000001000,
        ST_DET1  = 13'b0000000010000,
        ST_DET2  = 13'b0000000100000,
        ST_BOX   = 13'b0000001000000,
        ST_N1    = 13'b0000010000000,
        ST_N2    = 13'b0000100000000,
        ST_DIV1  = 13'b0001000000000,
        ST_DIV2  = 13'b0010000000000,
        ST_Z     = 13'b0100000000000,
        ST_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] color_mem [SIZE];
    logic [15:0] depth_mem [SIZE];
    logic [31:0] r_rd_color;
    logic [15:0] r_rd_depth;

    logic [SW-1:0] r_width, r_height;
    trd_pkg::t_in_item r_item;
    logic [XW-1:0] r_w;
    logic [YW-1:0] r_h;
    logic [AW:0]   r_cnt;
    logic [AW:0]   r_total;
    logic signed [33:0] r_det;
    logic signed [17:0] r_abx, r_aby, r_acx, r_acy;
    logic [XW-1:0] r_x, r_x0, r_x1;
    logic [YW-1:0] r_y, r_y1;
    logic signed [47:0] r_g1, r_g2;
    logic signed [33:0] r_n1, r_n2;
    logic [1:0]  r_sub;
    logic signed [34:0] r_acc;
    logic signed [47:0] r_zacc;
    logic [16:0] r_count;
    logic        r_out_valid;
    trd_pkg::t_out_item r_out;
    logic        r_wr_en;
    logic [AW-1:0] r_wr_addr;
    logic [15:0] r_wr_depth;

    trd_pkg::t_div_req w_req;
    trd_pkg::t_div_rsp w_rsp;

    trd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    function automatic logic signed [16:0] min3(input logic signed [15:0] a,
            input logic signed [15:0] b, input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return 17'((m < c) ? m : c);
    endfunction

    function automatic logic signed [16:0] max3(input logic signed [15:0] a,
            input logic signed [15:0] b, input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return 17'((m > c) ? m : c);
    endfunction

    // Shared multiplier.
    logic signed [17:0] w_ma, w_mb;
    logic signed [35:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic signed [17:0] w_pax, w_pay;
    assign w_pax = 18'(signed'({1'b0, r_x, 4'd0})) - 18'(r_item.ax);
    assign w_pay = 18'(signed'({1'b0, r_y, 4'd0})) - 18'(r_item.ay);

    logic signed [47:0] w_g3;
    assign w_g3 = 48'(trd_pkg::ONE_Q14) - r_g1 - r_g2;

    logic signed [17:0] w_bmin_x, w_bmax_x, w_bmin_y, w_bmax_y;
    assign w_bmin_x = 18'(min3(r_item.ax, r_item.bx, r_item.cx)) >>> 4;
    assign w_bmax_x = (18'(max3(r_item.ax, r_item.bx, r_item.cx)) + 18'sd15) >>> 4;
    assign w_bmin_y = 18'(min3(r_item.ay, r_item.by, r_item.cy)) >>> 4;
    assign w_bmax_y = (18'(max3(r_item.ay, r_item.by, r_item.cy)) + 18'sd15) >>> 4;

    logic signed [17:0] w_wlim, w_hlim;
    assign w_wlim = 18'(signed'({1'b0, r_w}));
    assign w_hlim = 18'(signed'({1'b0, r_h}));

    logic [AW+SW:0] w_pos;
    assign w_pos = (AW+SW+1)'(r_y) * (AW+SW+1)'(r_w) + (AW+SW+1)'(r_x);

    logic signed [47:0] w_zq;
    assign w_zq = r_zacc[47] ? -((-r_zacc) >>> 14) : (r_zacc >>> 14);
    logic signed [15:0] w_zsat;
    assign w_zsat = (w_zq > 48'sd32767) ? 16'sh7fff :
                    (w_zq < -48'sd32768) ? 16'sh8000 : w_zq[15:0];

    always_comb begin
        w_ma = r_abx;
        w_mb = r_acy;
        case (r_state)
            ST_DET1: begin w_ma = r_abx; w_mb = r_acy; end
            ST_DET2: begin
                w_ma = (r_sub == 2'd0) ? r_abx : r_acx;
                w_mb = (r_sub == 2'd0) ? r_acy : r_aby;
            end
            ST_N1: begin
                w_ma = (r_sub == 2'd0) ? w_pax : w_pay;
                w_mb = (r_sub == 2'd0) ? r_acy : r_acx;
            end
            ST_N2: begin
                w_ma = (r_sub == 2'd0) ? r_abx : r_aby;
                w_mb = (r_sub == 2'd0) ? w_pay : w_pax;
            end
            ST_Z: begin
                w_ma = (r_sub == 2'd0) ? 18'(r_item.az) :
                       (r_sub == 2'd1) ? 18'(r_item.bz) : 18'(r_item.cz);
                w_mb = (r_sub == 2'd0) ? w_g3[17:0] :
                       (r_sub == 2'd1) ? r_g1[17:0] : r_g2[17:0];
            end
            default: begin w_ma = r_abx; w_mb = r_acy; end
        endcase
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = '0;
        w_req.den   = r_det;
        if (r_state == ST_N2 && r_sub == 2'd2) begin
            w_req.start = 1'b1;
            w_req.num   = 48'(r_n1) <<< 14;
        end else if (r_state == ST_DIV1 && w_rsp.done) begin
            w_req.start = 1'b1;
            w_req.num   = 48'(r_n2) <<< 14;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) begin
                case (i_in_data.kind)
                    trd_pkg::KIND_CLEAR: n_state = ST_CLEAR;
                    trd_pkg::KIND_TRI:   n_state = ST_DET1;
                    trd_pkg::KIND_READ:  n_state = ST_READ;
                    default:             n_state = ST_DONE;
                endcase
            end
            ST_CLEAR: if (r_cnt + 1'b1 >= r_total) n_state = ST_DONE;
            ST_READ:  n_state = ST_READ2;
            ST_READ2: n_state = ST_DONE;
            ST_DET1:  n_state = ST_DET2;
            ST_DET2:  n_state = ST_BOX;
            ST_BOX:   n_state = ST_N1;
            default:  n_state = r_state;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            color_mem[r_wr_addr] <= r_item.fill_color;
            depth_mem[r_wr_addr] <= r_wr_depth;
        end
        r_rd_color <= color_mem[r_wr_addr];
        r_rd_depth <= depth_mem[r_wr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= SW'(256);
            r_height    <= SW'(256);
            r_out_valid <= 1'b0;
            r_wr_en     <= 1'b0;
        end else begin
            r_wr_en <= 1'b0;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == trd_pkg::CFG_WIDTH) r_width <= i_cfg_data;
                else r_height <= i_cfg_data;
            end
            r_state <= n_state;
            case (r_state)
                ST_IDLE: if (i_in_valid && !o_in_stall) begin
                    r_item  <= i_in_data;
                    r_w     <= (r_width == 0) ? XW'(1) :
                               (32'(r_width) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(r_width);
                    r_h     <= (r_height == 0) ? YW'(1) :
                               (32'(r_height) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) :
                               YW'(r_height);
                    r_cnt   <= '0;
                    r_count <= '0;
                    r_sub   <= '0;
                    r_out   <= '0;
                    r_wr_addr <= AW'(i_in_data.pixel_index);
                end else begin
                    r_state <= ST_IDLE;
                end
                ST_CLEAR: begin
                    r_wr_en    <= 1'b1;
                    r_wr_addr  <= r_cnt[AW-1:0];
                    r_wr_depth <= 16'hffff;
                    r_cnt      <= r_cnt + 1'b1;
                end
                ST_READ: ;
                ST_READ2: begin
                    if ({16'd0, r_item.pixel_index} < 32'(SIZE)) begin
                        r_out.read_color <= r_rd_color;
                        r_out.read_depth <= r_rd_depth;
                    end
                end
                ST_DET1: begin
                    r_abx <= 18'(r_item.bx) - 18'(r_item.ax);
                    r_aby <= 18'(r_item.by) - 18'(r_item.ay);
                    r_acx <= 18'(r_item.cx) - 18'(r_item.ax);
                    r_acy <= 18'(r_item.cy) - 18'(r_item.ay);
                end
                ST_DET2: begin
                    if (r_sub == 2'd0) begin
                        r_acc <= 35'(w_prod);
                        r_sub <= 2'd1;
                        r_state <= ST_DET2;
                    end else begin
                        r_det <= 34'(r_acc - 35'(w_prod));
                        r_sub <= 2'd0;
                    end
                end
                ST_BOX: begin
                    if (r_det > -34'sd256 && r_det < 34'sd256) begin
                        r_out.degenerate <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_x0 <= (w_bmin_x < 0) ? '0 : XW'(w_bmin_x);
                        r_x  <= (w_bmin_x < 0) ? '0 : XW'(w_bmin_x);
                        r_y  <= (w_bmin_y < 0) ? '0 : YW'(w_bmin_y);
                        r_x1 <= (w_bmax_x > w_wlim) ? r_w :
                                (w_bmax_x < 0) ? '0 : XW'(w_bmax_x);
                        r_y1 <= (w_bmax_y > w_hlim) ? r_h :
                                (w_bmax_y < 0) ? '0 : YW'(w_bmax_y);
                        if (w_bmin_x >= w_bmax_x || w_bmin_y >= w_bmax_y ||
                            w_bmin_x >= w_wlim || w_bmin_y >= w_hlim ||
                            w_bmax_x <= 0 || w_bmax_y <= 0)
                            r_state <= ST_DONE;
                    end
                end
                ST_N1: begin
                    if (r_x >= r_x1) begin
                        r_x <= r_x0;
                        r_y <= r_y + 1'b1;
                        if (r_y + 1'b1 >= r_y1) r_state <= ST_DONE;
                        else r_state <= ST_N1;
                    end else if (r_sub == 2'd0) begin
                        r_acc <= 35'(w_prod);
                        r_sub <= 2'd1;
                        r_state <= ST_N1;
                    end else begin
                        r_n1  <= 34'(r_acc - 35'(w_prod));
                        r_sub <= 2'd0;
                        r_state <= ST_N2;
                    end
                end
                ST_N2: begin
                    r_state <= ST_N2;
                    if (r_sub == 2'd0) begin
                        r_acc <= 35'(w_prod);
                        r_sub <= 2'd1;
                    end else if (r_sub == 2'd1) begin
                        r_n2  <= 34'(r_acc - 35'(w_prod));
                        r_sub <= 2'd2;
                    end else begin
                        r_sub <= 2'd0;
                        r_state <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    r_state <= ST_DIV1;
                    if (w_rsp.done) begin
                        r_g1 <= w_rsp.quo;
                        r_state <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    r_state <= ST_DIV2;
                    if (w_rsp.done) begin
                        r_g2 <= w_rsp.quo;
                        r_sub <= 2'd0;
                        r_wr_addr <= w_pos[AW-1:0];
                        r_state <= ST_Z;
                    end
                end
                ST_Z: begin
                    r_state <= ST_Z;
                    if (r_g1 < 0 || r_g2 < 0 || w_g3 < 0) begin
                        r_x <= r_x + 1'b1;
                        r_state <= ST_N1;
                    end else if (r_sub == 2'd0) begin
                        r_zacc <= 48'(w_prod);
                        r_sub <= 2'd1;
                    end else if (r_sub == 2'd1) begin
                        r_zacc <= r_zacc + 48'(w_prod);
                        r_sub <= 2'd2;
                    end else if (r_sub == 2'd2) begin
                        r_zacc <= r_zacc + 48'(w_prod);
                        r_sub <= 2'd3;
                    end else begin
                        r_sub <= 2'd0;
                        r_x <= r_x + 1'b1;
                        r_state <= ST_N1;
                        if ($signed(r_rd_depth) < w_zsat && w_pos < (AW+SW+1)'(SIZE)) begin
                            r_wr_en    <= 1'b1;
                            r_wr_depth <= w_zsat;
                            r_count    <= r_count + 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (r_item.kind == trd_pkg::KIND_TRI)
                        r_out.pixels_written <= r_count;
                    r_out_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
            if (r_state == ST_IDLE && i_in_valid && !o_in_stall &&
                i_in_data.kind == trd_pkg::KIND_CLEAR) begin
                r_total <= (AW+1)'((r_width == 0 ? 32'd1 :
                           (32'(r_width) > MAX_WIDTH ? 32'(MAX_WIDTH) : 32'(r_width))) *
                           (r_height == 0 ? 32'd1 :
                           (32'(r_height) > MAX_HEIGHT ? 32'(MAX_HEIGHT) : 32'(r_height))));
            end
            if (r_state == ST_IDLE && (!i_in_valid || o_in_stall)) r_state <= ST_IDLE;
        end
    end

endmodule
`default_nettype wire

// ===== verif/triangle_raster_depth_test_test.sv =====
`default_nettype none
module triangle_raster_depth_test_test;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int STORE_ENTRIES = 65536;

    typedef struct {
        trd_pkg::t_in_item  item;
        bit                 typed;
        trd_pkg::t_out_item want;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    trd_pkg::t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    trd_pkg::t_out_item o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_index = trd_pkg::CFG_WIDTH;
    logic [8:0] i_cfg_data = '0;

    triangle_raster_depth_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    logic [31:0]        pixel_color [0:STORE_ENTRIES-1];
    logic signed [15:0] pixel_depth [0:STORE_ENTRIES-1];
    logic [8:0]         width_reg = 9'd256;
    logic [8:0]         height_reg = 9'd256;
    trd_pkg::t_out_item pending_results [$];
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 items_sent = 0;
    int                 triangles_sent = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;

    function automatic int screen_w();
        if (width_reg < 1) return 1;
        if (width_reg > 256) return 256;
        return width_reg;
    endfunction

    function automatic int screen_h();
        if (height_reg < 1) return 1;
        if (height_reg > 256) return 256;
        return height_reg;
    endfunction

    function automatic trd_pkg::t_out_item raster_result(trd_pkg::t_in_item it);
        trd_pkg::t_out_item r;
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        longint abx, aby, acx, acy, det, pax, pay, n1, n2, g1, g2, g3, z;
        int x0, x1, y0, y1, w, h, pos, count;
        r = '0;
        w = screen_w();
        h = screen_h();
        if (it.kind == trd_pkg::KIND_CLEAR) begin
            for (int i = 0; i < w * h; i++) begin
                pixel_color[i] = it.fill_color;
                pixel_depth[i] = -16'sd1;
            end
        end else if (it.kind == trd_pkg::KIND_READ) begin
            r.read_color = pixel_color[it.pixel_index];
            r.read_depth = pixel_depth[it.pixel_index];
        end else if (it.kind == trd_pkg::KIND_TRI) begin
            ax = it.ax; ay = it.ay; az = it.az;
            bx = it.bx; by = it.by; bz = it.bz;
            cx = it.cx; cy = it.cy; cz = it.cz;
            abx = bx - ax; aby = by - ay;
            acx = cx - ax; acy = cy - ay;
            det = abx * acy - acx * aby;
            if (det > -256 && det < 256) begin
                r.degenerate = 1'b1;
                return r;
            end
            x0 = int'(((ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx)) + 32768) / 16
                      - 2048);
            x1 = int'(((ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx)) + 32783) / 16
                      - 2048);
            y0 = int'(((ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy)) + 32768) / 16
                      - 2048);
            y1 = int'(((ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy)) + 32783) / 16
                      - 2048);
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > w) x1 = w;
            if (y1 > h) y1 = h;
            count = 0;
            for (int y = y0; y < y1; y++) begin
                pay = longint'(y) * 16 - ay;
                for (int x = x0; x < x1; x++) begin
                    pax = longint'(x) * 16 - ax;
                    n1 = pax * acy - pay * acx;
                    n2 = abx * pay - aby * pax;
                    g1 = (n1 * 16384) / det;
                    g2 = (n2 * 16384) / det;
                    g3 = 16384 - g1 - g2;
                    if (g1 < 0 || g2 < 0 || g3 < 0) continue;
                    z = (az * g3 + bz * g1 + cz * g2) / 16384;
                    if (z > 32767) z = 32767;
                    if (z < -32768) z = -32768;
                    pos = y * w + x;
                    if (longint'(pixel_depth[pos]) < z) begin
                        pixel_depth[pos] = z[15:0];
                        pixel_color[pos] = it.fill_color;
                        count++;
                    end
                end
            end
            r.pixels_written = count[16:0];
        end
        return r;
    endfunction

    function automatic trd_pkg::t_in_item tri_item(int ax, int ay, int az, int bx, int by,
                                                   int bz, int cx, int cy, int cz,
                                                   logic [31:0] color);
        trd_pkg::t_in_item it;
        it = '0;
        it.kind = trd_pkg::KIND_TRI;
        it.ax = ax[15:0]; it.ay = ay[15:0]; it.az = az[15:0];
        it.bx = bx[15:0]; it.by = by[15:0]; it.bz = bz[15:0];
        it.cx = cx[15:0]; it.cy = cy[15:0]; it.cz = cz[15:0];
        it.fill_color = color;
        return it;
    endfunction

    function automatic trd_pkg::t_in_item plain_item(logic [1:0] kind, logic [31:0] color,
                                                     logic [15:0] index);
        trd_pkg::t_in_item it;
        it = '0;
        it.kind = kind;
        it.fill_color = color;
        it.pixel_index = index;
        return it;
    endfunction

    function automatic trd_pkg::t_out_item read_out(logic [31:0] color,
                                                    logic signed [15:0] depth);
        trd_pkg::t_out_item r;
        r = '0;
        r.read_color = color;
        r.read_depth = depth;
        return r;
    endfunction

    task automatic send_item(trd_pkg::t_in_item it, bit typed, trd_pkg::t_out_item want);
        trd_pkg::t_out_item predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        predicted = raster_result(it);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        if (it.kind == trd_pkg::KIND_TRI) triangles_sent++;
    endtask

    task automatic write_screen(logic index, logic [8:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == trd_pkg::CFG_WIDTH) width_reg = value;
        else height_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic trd_pkg::t_in_item random_item();
        trd_pkg::t_in_item it;
        int pick, w, h, px, py, qx, qy, rx, ry;
        w = screen_w();
        h = screen_h();
        pick = $urandom_range(99);
        it = '0;
        it.fill_color = $urandom;
        it.pixel_index = 16'($urandom);
        if (pick < 8 && w * h <= 8192) begin
            it.kind = trd_pkg::KIND_CLEAR;
        end else if (pick < 12) begin
            it = {2'd0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it.kind = KIND_SPARE;
        end else if (pick < 45) begin
            it.kind = trd_pkg::KIND_READ;
            if ($urandom_range(9) < 7) it.pixel_index = 16'($urandom_range(w * h - 1));
        end else begin
            px = int'($urandom_range((w + 4) * 16)) - 32;
            py = int'($urandom_range((h + 4) * 16)) - 32;
            qx = px + int'($urandom_range(192)) - 96;
            qy = py + int'($urandom_range(192)) - 96;
            if ($urandom_range(9) == 0) begin
                rx = px + 2 * (qx - px);
                ry = py + 2 * (qy - py);
            end else begin
                rx = px + int'($urandom_range(192)) - 96;
                ry = py + int'($urandom_range(192)) - 96;
            end
            it = tri_item(px, py, $urandom, qx, qy, $urandom, rx, ry, $urandom, $urandom);
        end
        return it;
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        trd_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item: %p", o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.read_color !== want.read_color
                        || o_out_data.read_depth !== want.read_depth
                        || o_out_data.pixels_written !== want.pixels_written
                        || o_out_data.degenerate !== want.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d mismatch: expected %p, got %p",
                                 results_seen, want, o_out_data);
                end
            end
        end
    end

    initial begin
        #(12 * 20000000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_row rows [$];
        trd_pkg::t_in_item spare;
        logic [8:0] widths [7];
        logic [8:0] heights [7];
        widths = '{9'd0, 9'd511, 9'd9, 9'd256, 9'd1, 9'd33, 9'd16};
        heights = '{9'd0, 9'd5, 9'd256, 9'd1, 9'd256, 9'd20, 9'd16};
        spare = '1;
        spare.kind = KIND_SPARE;

        rows.push_back('{plain_item(trd_pkg::KIND_READ, 0, 16'd0), 1,
                         read_out(32'hA5A55A5A, -16'sd1)});
        rows.push_back('{plain_item(trd_pkg::KIND_READ, 0, 16'hFFFF), 1,
                         read_out(32'hA5A55A5A, -16'sd1)});
        rows.push_back('{plain_item(trd_pkg::KIND_CLEAR, 32'hFFFFFFFF, 16'd0), 1, '0});
        rows.push_back('{plain_item(trd_pkg::KIND_READ, 0, 16'd255), 1,
                         read_out(32'hFFFFFFFF, -16'sd1)});
        rows.push_back('{tri_item(40, 40, 100, 40, 40, 100, 40, 40, 100, 32'h1), 1,
                         trd_pkg::t_out_item'{0, 0, 0, 1'b1}});
        rows.push_back('{tri_item(0, 0, 5, 15, 0, 5, 0, 17, 5, 32'h2), 1,
                         trd_pkg::t_out_item'{0, 0, 0, 1'b1}});
        rows.push_back('{tri_item(0, 0, 5, 0, 17, 5, 15, 0, 5, 32'h3), 1,
                         trd_pkg::t_out_item'{0, 0, 0, 1'b1}});
        rows.push_back('{tri_item(0, 0, 300, 16, 0, 300, 0, 16, 300, 32'h4), 0, '0});
        rows.push_back('{tri_item(-200, -200, 9, -100, -200, 9, -200, -100, 9, 32'h5), 1, '0});
        rows.push_back('{tri_item(-32768, -32768, 32767, 32767, -32768, -32768,
                                  -32768, 32767, 0, 32'h00FF00FF), 0, '0});
        rows.push_back('{tri_item(-32768, -32768, 0, -32768, 32767, 32767,
                                  32767, -32768, 32767, 32'hFF00FF00), 0, '0});
        rows.push_back('{tri_item(8, 8, -32768, 200, 20, -32768, 30, 220, -32768,
                                  32'h6), 1, '0});
        rows.push_back('{tri_item(8, 8, 32767, 200, 20, 32767, 30, 220, 32767,
                                  32'h80000000), 0, '0});
        rows.push_back('{spare, 1, '0});
        rows.push_back('{plain_item(trd_pkg::KIND_READ, 0, 16'd0), 0, '0});
        rows.push_back('{plain_item(trd_pkg::KIND_READ, 0, 16'd34), 0, '0});
        rows.push_back('{plain_item(trd_pkg::KIND_READ, 0, 16'd255), 0, '0});
        rows.push_back('{plain_item(trd_pkg::KIND_READ, 0, 16'd256), 0, '0});

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(plain_item(trd_pkg::KIND_CLEAR, 32'hA5A55A5A, 16'd0), 1, '0);
        write_screen(trd_pkg::CFG_WIDTH, 9'd16);
        write_screen(trd_pkg::CFG_HEIGHT, 9'd16);
        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

        for (int p = 0; p < 7; p++) begin
            write_screen(trd_pkg::CFG_WIDTH, widths[p]);
            write_screen(trd_pkg::CFG_HEIGHT, heights[p]);
            send_idle_pct = (p < 2) ? 13 : (p < 4) ? 76 : 0;
            stall_pct = (p < 2) ? 76 : (p < 4) ? 13 : 0;
            for (int n = 0; n < 17; n++) send_item(random_item(), 0, '0);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items, %0d of them triangles, over eight screen sizes;",
                 items_sent, triangles_sent);
        $display("checked %0d result items, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
